[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/u8cp_pkg.sv]
// ----------------------------------------------------------------------------
// u8cp_pkg
// Types and constants for the UTF-8 to code point decoder.
// ----------------------------------------------------------------------------
package u8cp_pkg;

	localparam int CpW  = 21;
	localparam int CntW = 3;

	localparam logic [CpW-1:0] CpRepl = 21'h00FFFD;

	localparam logic [7:0] ByteCont  = 8'h80;
	localparam logic [7:0] ByteLead2 = 8'hC0;
	localparam logic [7:0] ByteLead3 = 8'hE0;
	localparam logic [7:0] ByteLead4 = 8'hF0;
	localparam logic [7:0] ByteBad   = 8'hF8;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} byte_item_t;

	typedef struct packed {
		logic [CpW-1:0] code_point;
		logic           replaced;
		logic           final_of_run;
		logic           text_done;
	} cp_item_t;

endpackage

[rtl/utf8_to_code_point_decoder.sv]
// ----------------------------------------------------------------------------
// utf8_to_code_point_decoder
// Streaming UTF-8 decoder: one text byte in, zero to four code points out.
// ----------------------------------------------------------------------------
// A byte is decoded in the cycle of its transfer and its results appear on the
// code point channel in the next cycle. While cp_ready is high, the single
// result register drains one code point per cycle, so bytes that yield zero
// or one result each flow at one byte per cycle, while a byte with n results
// (up to four, for a broken or cut-off sequence) holds the byte channel until
// its last result is taken. Malformed input gives 0xFFFD with replaced set;
// the decoder is idle after every byte flagged end_of_text.
`include "assert_macros.svh"

module utf8_to_code_point_decoder
	import u8cp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_ready,
	input  byte_item_t byte_data,
	output logic       cp_valid,
	input  logic       cp_ready,
	output cp_item_t   cp_data
);

	logic [CpW-1:0]  pv_q;
	logic [1:0]      need_q;
	logic [1:0]      held_q;
	logic [CntW-1:0] cnt_q;
	logic [CpW-1:0]  cp_q;
	logic            rep_q;
	logic            done_q;

	logic [7:0]      b;
	logic            last;
	logic            accept;

	logic            f_emit;
	logic [CpW-1:0]  f_cp;
	logic            f_rep;
	logic            f_lead;
	logic [1:0]      f_need;
	logic [CpW-1:0]  f_bits;

	logic [CpW-1:0]  pv_sh;
	logic [1:0]      need_dec;
	logic [1:0]      held_inc;

	logic [CntW-1:0] n_d;
	logic [CpW-1:0]  cp_d;
	logic            rep_d;
	logic [CpW-1:0]  pv_d;
	logic [1:0]      need_d;
	logic [1:0]      held_d;

	assign b      = byte_data.text_byte;
	assign last   = byte_data.end_of_text;
	assign cp_valid   = (cnt_q != '0);
	assign byte_ready = (cnt_q == '0) || ((cnt_q == CntW'(1)) && cp_ready);
	assign accept     = byte_valid && byte_ready;

	// decode a byte with no lead held
	always_comb begin
		f_emit = 1'b0;
		f_cp   = CpRepl;
		f_rep  = 1'b1;
		f_lead = 1'b0;
		f_need = 2'd0;
		f_bits = '0;
		if (b < ByteCont) begin
			f_emit = 1'b1;
			f_cp   = CpW'(b);
			f_rep  = 1'b0;
		end else if (b < ByteLead2 || b >= ByteBad) begin
			f_emit = 1'b1;
		end else begin
			if (b >= ByteLead4) begin
				f_need = 2'd3;
				f_bits = CpW'(b[2:0]);
			end else if (b >= ByteLead3) begin
				f_need = 2'd2;
				f_bits = CpW'(b[3:0]);
			end else begin
				f_need = 2'd1;
				f_bits = CpW'(b[4:0]);
			end
			if (last) begin
				f_emit = 1'b1;
			end else begin
				f_lead = 1'b1;
			end
		end
	end

	assign pv_sh    = {pv_q[CpW-7:0], b[5:0]};
	assign need_dec = need_q - 2'd1;
	assign held_inc = held_q + 2'd1;

	always_comb begin
		n_d    = '0;
		cp_d   = CpRepl;
		rep_d  = 1'b1;
		pv_d   = '0;
		need_d = 2'd0;
		held_d = 2'd0;
		if (need_q == 2'd0) begin
			n_d   = CntW'(f_emit);
			cp_d  = f_cp;
			rep_d = f_rep;
			if (f_lead) begin
				pv_d   = f_bits;
				need_d = f_need;
			end
		end else if (b >= ByteCont && b < ByteLead2) begin
			if (need_dec == 2'd0) begin
				n_d   = CntW'(1);
				cp_d  = pv_sh;
				rep_d = 1'b0;
			end else if (last) begin
				n_d = CntW'(held_inc) + CntW'(1);
			end else begin
				pv_d   = pv_sh;
				need_d = need_dec;
				held_d = held_inc;
			end
		end else begin
			n_d = CntW'(held_q) + CntW'(1) + CntW'(f_emit);
			if (f_emit) begin
				cp_d  = f_cp;
				rep_d = f_rep;
			end
			if (f_lead) begin
				pv_d   = f_bits;
				need_d = f_need;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q   <= '0;
			need_q <= 2'd0;
			held_q <= 2'd0;
			cnt_q  <= '0;
		end else begin
			if (accept) begin
				pv_q   <= pv_d;
				need_q <= need_d;
				held_q <= held_d;
				cnt_q  <= n_d;
			end else if (cp_valid && cp_ready) begin
				cnt_q <= cnt_q - CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cp_q   <= cp_d;
			rep_q  <= rep_d;
			done_q <= last;
		end
	end

	// all but the final result of a byte are replacements
	always_comb begin
		if (cnt_q == CntW'(1)) begin
			cp_data.code_point   = cp_q;
			cp_data.replaced     = rep_q;
			cp_data.final_of_run = 1'b1;
			cp_data.text_done    = done_q;
		end else begin
			cp_data.code_point   = CpRepl;
			cp_data.replaced     = 1'b1;
			cp_data.final_of_run = 1'b0;
			cp_data.text_done    = 1'b0;
		end
	end

	`ASSERT_CLK(a_cnt_range, cnt_q <= CntW'(4), "result count out of range")
	`ASSERT_CLK(a_seq_len, CntW'(held_q) + CntW'(need_q) <= CntW'(3), "sequence length overrun")
	`ASSERT_CLK(a_no_overrun, !accept || cnt_q <= CntW'(1), "byte transfer over pending results")
	`ASSERT_NEXT(a_idle_after_end, accept && last, (need_q | held_q) == 2'd0, "busy after end")

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming UTF-8 to code point decoder.
// Bytes go in over a valid/ready channel with random gaps. The code point
// channel is stalled at random. A local decoder model predicts every code
// point, and each transfer on the output side is compared field by field,
// in order, with the oldest prediction. Directed strings cover ASCII, the
// two-byte extremes, the largest three- and four-byte sequences and each kind
// of malformed input. Random text, mostly well-formed with noise, follows.
// ----------------------------------------------------------------------------
module tb;
	import u8cp_pkg::*;

	localparam int LimitCycles = 400000;
	localparam int RandItems   = 355;
	localparam int TailCycles  = 8;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       byte_valid = 1'b0;
	logic       byte_ready;
	byte_item_t byte_data  = '0;
	logic       cp_valid;
	logic       cp_ready   = 1'b0;
	cp_item_t   cp_data;

	utf8_to_code_point_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_data (byte_data),
		.cp_valid  (cp_valid),
		.cp_ready  (cp_ready),
		.cp_data   (cp_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Decoder model state
	logic [CpW-1:0] acc_value;
	logic [1:0]     conts_needed;
	logic [1:0]     conts_held;

	cp_item_t cp_expected[$];
	cp_item_t byte_results[$];

	int  mismatch_cnt = 0;
	int  cycle_cnt    = 0;
	int  bytes_sent   = 0;
	int  stall_left   = 0;
	bit  no_idle      = 1'b0;

	function automatic void decoder_idle();
		acc_value    = '0;
		conts_needed = '0;
		conts_held   = '0;
	endfunction

	function automatic void push_code_point(logic [CpW-1:0] cp, logic rep);
		cp_item_t item;
		item.code_point   = cp;
		item.replaced     = rep;
		item.final_of_run = 1'b0;
		item.text_done    = 1'b0;
		byte_results.push_back(item);
	endfunction

	function automatic void decode_fresh(logic [7:0] b, logic eot);
		if (b < ByteCont) begin
			push_code_point(CpW'(b), 1'b0);
		end else if (b < ByteLead2 || b >= ByteBad) begin
			push_code_point(CpRepl, 1'b1);
		end else if (eot) begin
			push_code_point(CpRepl, 1'b1);
		end else begin
			if (b >= ByteLead4) begin
				conts_needed = 2'd3;
				acc_value    = CpW'(b - ByteLead4);
			end else if (b >= ByteLead3) begin
				conts_needed = 2'd2;
				acc_value    = CpW'(b - ByteLead3);
			end else begin
				conts_needed = 2'd1;
				acc_value    = CpW'(b - ByteLead2);
			end
			conts_held = '0;
		end
	endfunction

	function automatic void decode_byte(logic [7:0] b, logic eot);
		int held;
		byte_results.delete();
		if (conts_needed == 0) begin
			decode_fresh(b, eot);
		end else if (b >= ByteCont && b < ByteLead2) begin
			acc_value    = {acc_value[CpW-7:0], b[5:0]};
			conts_needed = conts_needed - 2'd1;
			if (conts_needed == 0) begin
				push_code_point(acc_value, 1'b0);
				decoder_idle();
			end else begin
				conts_held = conts_held + 2'd1;
				if (eot) begin
					for (int i = 0; i <= conts_held; i++)
						push_code_point(CpRepl, 1'b1);
					decoder_idle();
				end
			end
		end else begin
			held = int'(conts_held);
			for (int i = 0; i <= held; i++)
				push_code_point(CpRepl, 1'b1);
			decoder_idle();
			decode_fresh(b, eot);
		end
		if (byte_results.size() > 0) begin
			byte_results[$].final_of_run = 1'b1;
			byte_results[$].text_done    = eot;
		end
		foreach (byte_results[i])
			cp_expected.push_back(byte_results[i]);
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle)
			return 0;
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic pick_eot(int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic eot);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid            <= 1'b1;
		byte_data.text_byte   <= b;
		byte_data.end_of_text <= eot;
		@(posedge clk);
		while (!byte_ready) @(posedge clk);
		decode_byte(b, eot);
		bytes_sent++;
	endtask

	always @(posedge clk) begin : drive_cp_ready
		int g;
		if (stall_left > 0) begin
			cp_ready <= 1'b0;
			stall_left--;
		end else begin
			g = pick_gap();
			if (g > 0) begin
				cp_ready   <= 1'b0;
				stall_left = g - 1;
			end else begin
				cp_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_cp
		cp_item_t want;
		if (arst_n && cp_valid && cp_ready) begin
			if (cp_expected.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("unexpected transfer: cp=%h rep=%b fin=%b done=%b",
						cp_data.code_point, cp_data.replaced,
						cp_data.final_of_run, cp_data.text_done);
			end else begin
				want = cp_expected.pop_front();
				if (cp_data.code_point !== want.code_point ||
					cp_data.replaced !== want.replaced ||
					cp_data.final_of_run !== want.final_of_run ||
					cp_data.text_done !== want.text_done) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("mismatch: exp %h/%b/%b/%b got %h/%b/%b/%b",
							want.code_point, want.replaced,
							want.final_of_run, want.text_done,
							cp_data.code_point, cp_data.replaced,
							cp_data.final_of_run, cp_data.text_done);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > LimitCycles) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic test_ascii();
		send_byte(8'h00, 1'b0);
		send_byte(8'h7F, 1'b1);
	endtask

	task automatic test_sequences();
		send_byte(ByteLead2, 1'b0);
		send_byte(ByteCont, 1'b0);
		send_byte(8'hDF, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hEF, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hF7, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hBF, 1'b1);
	endtask

	task automatic test_malformed();
		// lone continuation, invalid lead
		send_byte(ByteCont, 1'b0);
		send_byte(8'hFF, 1'b0);
		// broken right after the lead
		send_byte(8'hE2, 1'b0);
		send_byte(8'h41, 1'b0);
		// broken with two continuations held
		send_byte(ByteLead4, 1'b0);
		send_byte(ByteCont, 1'b0);
		send_byte(ByteCont, 1'b0);
		send_byte(8'h55, 1'b0);
		// lead at end of text
		send_byte(8'hC3, 1'b1);
		// cut off by end of text
		send_byte(ByteLead4, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'hBF, 1'b1);
	endtask

	task automatic test_random_text();
		int target;
		int len;
		int kind;
		logic [7:0] lead;
		target = bytes_sent + RandItems;
		while (bytes_sent < target) begin
			if ($urandom_range(0, 39) == 0)
				no_idle = !no_idle;
			kind = $urandom_range(0, 99);
			if (kind < 75) begin
				len = $urandom_range(1, 4);
				case (len)
					1: lead = 8'($urandom_range(0, 127));
					2: lead = ByteLead2 | 8'($urandom_range(0, 31));
					3: lead = ByteLead3 | 8'($urandom_range(0, 15));
					default: lead = ByteLead4 | 8'($urandom_range(0, 7));
				endcase
				send_byte(lead, (len == 1) ? pick_eot(15) : pick_eot(3));
				for (int k = 1; k < len; k++)
					send_byte(ByteCont | 8'($urandom_range(0, 63)),
						pick_eot((k == len - 1) ? 15 : 3));
			end else if (kind < 85) begin
				send_byte(8'($urandom_range(0, 255)), pick_eot(20));
			end else if (kind < 95) begin
				len = $urandom_range(2, 4);
				lead = (len == 2) ? ByteLead2 : (len == 3) ? ByteLead3 : ByteLead4;
				send_byte(lead | 8'($urandom_range(0, 7)), pick_eot(10));
				repeat ($urandom_range(0, len - 2))
					send_byte(ByteCont | 8'($urandom_range(0, 63)), pick_eot(10));
			end else begin
				send_byte(ByteCont | 8'($urandom_range(0, 63)), pick_eot(10));
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		decoder_idle();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_ascii();
		test_sequences();
		test_malformed();
		test_random_text();

		byte_valid <= 1'b0;
		while (cp_expected.size() != 0) @(posedge clk);
		repeat (TailCycles) @(posedge clk);

		if (mismatch_cnt == 0 && cp_expected.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
